FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/fmop_pkg.sv
// ---------------------------------------------------------------------------
// fmop_pkg
// Shared widths, constants and the quarter-wave sine generator.
// ---------------------------------------------------------------------------
`default_nettype none

package fmop_pkg;

    localparam int INC_W       = 31;
    localparam int MOD_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;
    localparam int GAIN_W      = 16;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam int SCALE_W     = 64;
    localparam int MOD_K_W     = 33;
    localparam int MOD_PROD_W  = MOD_W + MOD_K_W;
    localparam int FB_PROD_W   = GAIN_W + 1 + SAMPLE_W;

    // mod product is in units of 2^-47 of a phase turn, feedback product in 2^-27
    localparam int MOD_REF_SHIFT = 47;
    localparam int FB_REF_SHIFT  = 27;

    // round(5 / (2*pi) * 2^32)
    localparam logic [MOD_K_W-1:0] MOD_K = 33'd3417826378;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint FULL_SCALE  = 64'sd32767;

    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_GAIN = 1'b0;

    // 32767*sin(pi/2 * q / 2^qbits), Q30 Taylor series up to x^11
    function automatic logic [MAG_W-1:0] quarter_sine(input longint q, input int qbits);
        longint x;
        longint x2;
        longint t;
        longint s;
        longint r;
        x  = (q * HALF_PI_Q30 + (64'sd1 <<< (qbits - 1))) >>> qbits;
        x2 = (x * x) >>> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
        s  = (x * t) >>> 30;
        r  = (s * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
        if (r > FULL_SCALE) begin
            r = FULL_SCALE;
        end
        if (r < 0) begin
            r = 0;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/fmop_sine_rom.sv
// ---------------------------------------------------------------------------
// fmop_sine_rom
// Quarter-wave sine table with quadrant mirroring and a registered output.
// The output register holds the last sample and resets to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module fmop_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire logic [ADDR_BITS-1:0]                 index,
    output logic signed [fmop_pkg::SAMPLE_W-1:0]      sample
);
    import fmop_pkg::*;

    localparam int QBITS   = ADDR_BITS - 2;
    localparam int QUARTER = 1 << QBITS;

    logic [MAG_W-1:0]           sine_tbl [QUARTER+1];
    logic [1:0]                 quad;
    logic [QBITS-1:0]           q_low;
    logic [QBITS:0]             q_sel;
    logic [SAMPLE_W-1:0]        mag_ext;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic signed [SAMPLE_W-1:0] sample_reg;

    for (genvar i = 0; i <= QUARTER; i++) begin : g_tbl
        assign sine_tbl[i] = quarter_sine(longint'(i), QBITS);
    end

    assign quad  = index[ADDR_BITS-1 -: 2];
    assign q_low = index[QBITS-1:0];

    always_comb begin
        if (quad[0]) begin
            q_sel = (QBITS+1)'(QUARTER) - {1'b0, q_low};
        end else begin
            q_sel = {1'b0, q_low};
        end
        mag_ext = {1'b0, sine_tbl[q_sel]};
        if (quad[1]) begin
            sample_next = SAMPLE_W'(0) - mag_ext;
        end else begin
            sample_next = mag_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (en) begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

FILE: src/fm_operator_sine_feedback_core.sv
// Each input beat passes the stage 1 registers, base_reg and the ROM output register.
// Throughput: one beat per cycle when the output is not stalled; the feedback
// loop (gain multiply, phase add, sine lookup) closes through the output register.
// Reset clears phase accumulator, last sample, feedback gain and all valids.
// ---------------------------------------------------------------------------
// fm_operator_sine_feedback_core
// FM sine operator with self-feedback: phase accumulate, modulation and
// feedback offset, quarter-wave sine lookup.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fm_operator_sine_feedback_core #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata: [30:0] phase_increment, [46:31] modulation, [47] zero
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [fmop_pkg::S_DATA_W-1:0]        s_tdata,
    // m_tdata: [15:0] sample
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [fmop_pkg::M_DATA_W-1:0]             m_tdata,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [fmop_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [fmop_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fmop_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);
    import fmop_pkg::*;

    localparam int MOD_SH  = PHASE_BITS - MOD_REF_SHIFT;
    localparam int MOD_LSH = (MOD_SH > 0) ? MOD_SH : 0;
    localparam int MOD_RSH = (MOD_SH < 0) ? -MOD_SH : 0;
    localparam int FB_SH   = PHASE_BITS - FB_REF_SHIFT;
    localparam int FB_LSH  = (FB_SH > 0) ? FB_SH : 0;
    localparam int FB_RSH  = (FB_SH < 0) ? -FB_SH : 0;

    logic                         accept;
    logic                         s2_load;
    logic                         out_load;
    logic                         reg_hit;
    logic                         cfg_wr;

    logic [GAIN_W-1:0]            gain_reg;
    logic [PHASE_BITS-1:0]        phase_acc_reg;
    logic [PHASE_BITS-1:0]        phase_acc_next;
    logic signed [MOD_PROD_W-1:0] mod_prod_reg;
    logic signed [MOD_PROD_W-1:0] mod_prod_next;
    logic                         v1_reg;
    logic                         v1_next;
    logic [PHASE_BITS-1:0]        base_reg;
    logic [PHASE_BITS-1:0]        base_next;
    logic                         v2_reg;
    logic                         v2_next;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;

    logic [SCALE_W-1:0]           inc_wide;
    logic signed [MOD_W-1:0]      mod_in;
    logic signed [SCALE_W-1:0]    mod_wide;
    logic signed [SCALE_W-1:0]    mod_scaled;
    logic signed [FB_PROD_W-1:0]  fb_prod;
    logic signed [SCALE_W-1:0]    fb_wide;
    logic signed [SCALE_W-1:0]    fb_scaled;
    logic [PHASE_BITS-1:0]        addr;
    logic signed [SAMPLE_W-1:0]   sample_q;

    // pipeline flow
    assign out_load = v2_reg && (!m_tvalid_reg || m_tready);
    assign s2_load  = v1_reg && (!v2_reg || out_load);
    assign s_tready = !v1_reg || s2_load;
    assign accept   = s_tvalid && s_tready;

    assign v1_next       = accept || (v1_reg && !s2_load);
    assign v2_next       = s2_load || (v2_reg && !out_load);
    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    // stage 1: phase accumulate, modulation product
    assign inc_wide       = SCALE_W'(s_tdata[INC_W-1:0]);
    assign phase_acc_next = phase_acc_reg + inc_wide[PHASE_BITS-1:0];
    assign mod_in         = s_tdata[INC_W +: MOD_W];
    assign mod_prod_next  = mod_in * $signed(MOD_K);

    // stage 2: add scaled modulation
    assign mod_wide   = SCALE_W'(mod_prod_reg);
    assign mod_scaled = (mod_wide <<< MOD_LSH) >>> MOD_RSH;
    assign base_next  = phase_acc_reg + mod_scaled[PHASE_BITS-1:0];

    // feedback loop: last sample times gain into the table address
    assign fb_prod   = $signed({1'b0, gain_reg}) * sample_q;
    assign fb_wide   = SCALE_W'(fb_prod);
    assign fb_scaled = (fb_wide <<< FB_LSH) >>> FB_RSH;
    assign addr      = base_reg + fb_scaled[PHASE_BITS-1:0];

    fmop_sine_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (out_load),
        .index   (addr[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
        .sample  (sample_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = sample_q;

    // register port
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_FEEDBACK_GAIN);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DATA_W'(gain_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= '0;
            phase_acc_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                gain_reg <= pwdata[GAIN_W-1:0];
            end
            if (accept) begin
                phase_acc_reg <= phase_acc_next;
            end
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mod_prod_reg <= mod_prod_next;
        end
        if (s2_load) begin
            base_reg <= base_next;
        end
    end

    `ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, accept, v1_reg)
    `ASSERT_NEXT(a_phase_holds, aclk, aresetn, v1_reg && !s2_load, v1_reg && $stable(phase_acc_reg))
    `ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_tvalid_reg && !m_tready, !out_load)
    `ASSERT_NEXT(a_fb_holds, aclk, aresetn, !out_load, $stable(sample_q))

endmodule

`default_nettype wire

FILE: test/fm_operator_sine_feedback_core_test.sv
// ---------------------------------------------------------------------------
// fm_operator_sine_feedback_core_test
// Drives phase increment / modulation beats into the FM operator, predicts
// each output sample with a local phase accumulator, feedback path and sine
// table, and checks every result beat in order. Covers quadrant points, field
// extremes, feedback gain settings over APB, random traffic under several
// idle/stall mixes and a long receiver hold-off.
// ---------------------------------------------------------------------------
module fm_operator_sine_feedback_core_test;

    localparam int PHASE_W   = 32;
    localparam int LUT_BITS  = 10;
    localparam int QTR_BITS  = LUT_BITS - 2;
    localparam int INC_W     = fmop_pkg::INC_W;
    localparam int MOD_W     = fmop_pkg::MOD_W;
    localparam int SAMPLE_W  = fmop_pkg::SAMPLE_W;
    localparam int GAIN_W    = fmop_pkg::GAIN_W;
    localparam int ADDR_W    = fmop_pkg::APB_ADDR_W;
    localparam int PDATA_W   = fmop_pkg::APB_DATA_W;
    localparam int HOLD_CYCLES = 300;

    localparam logic [INC_W-1:0] INC_MAX     = '1;
    localparam logic [INC_W-1:0] INC_QUARTER = INC_W'(1) << (PHASE_W - 2);
    localparam logic signed [MOD_W-1:0] MOD_MIN = 16'sh8000;
    localparam logic signed [MOD_W-1:0] MOD_MAX = 16'sh7fff;

    localparam logic [ADDR_W-1:0] GAIN_ADDR     = {fmop_pkg::REG_FEEDBACK_GAIN, 2'b00};
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = {~fmop_pkg::REG_FEEDBACK_GAIN, 2'b00};

    // 5 rad per full scale, in units of 2^-47 of a phase turn
    localparam longint MOD_STEP   = 64'sd3417826378;
    localparam longint HALF_PI    = 64'sd1686629713;
    localparam longint UNITY_Q30  = 64'sd1 <<< 30;
    localparam longint PEAK       = 64'sd32767;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [fmop_pkg::S_DATA_W-1:0]   s_tdata  = '0;  // [30:0] phase_increment, [46:31] modulation
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fmop_pkg::M_DATA_W-1:0]   m_tdata;        // [15:0] sample
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [ADDR_W-1:0]               paddr    = '0;
    logic [PDATA_W-1:0]              pwdata   = '0;
    logic [PDATA_W-1:0]              prdata;
    logic                            pready;

    fm_operator_sine_feedback_core #(
        .PHASE_BITS      (PHASE_W),
        .TABLE_ADDR_BITS (LUT_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // operator state mirror
    logic [PHASE_W-1:0]         tone_phase;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic [GAIN_W-1:0]          fb_gain;
    logic signed [SAMPLE_W-1:0] sine_lut [0:(1 << LUT_BITS)-1];

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] want_sample;
    int                         fail_count      = 0;
    int                         sender_idle_pct = 0;
    int                         stall_pct       = 0;
    logic                       hold_start      = 1'b0;
    logic                       hold_taken      = 1'b0;
    int                         hold_left       = 0;

    // Q30 Taylor series of sin over the first quadrant, scaled to Q1.15
    function automatic logic signed [SAMPLE_W-1:0] quadrant_sine(input longint step);
        longint ang;
        longint ang_sq;
        longint acc;
        longint prod;
        ang = (step * HALF_PI + (64'sd1 <<< (QTR_BITS - 1))) >>> QTR_BITS;
        ang_sq = (ang * ang) >>> 30;
        acc = UNITY_Q30;
        for (int n = 5; n >= 1; n--) begin
            acc = UNITY_Q30 - ((ang_sq * acc) >>> 30) / ((2 * n) * (2 * n + 1));
        end
        prod = (((ang * acc) >>> 30) * PEAK + (64'sd1 <<< 29)) >>> 30;
        if (prod > PEAK) begin
            prod = PEAK;
        end
        if (prod < 0) begin
            prod = 0;
        end
        return SAMPLE_W'(prod);
    endfunction

    task automatic fill_sine_lut();
        logic [1:0] quad;
        longint     step;
        for (int i = 0; i < (1 << LUT_BITS); i++) begin
            quad = 2'(i >> QTR_BITS);
            step = i % (1 << QTR_BITS);
            if (quad[0]) begin
                step = (1 << QTR_BITS) - step;
            end
            sine_lut[i] = quad[1] ? -quadrant_sine(step) : quadrant_sine(step);
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] next_sample(
        input logic [INC_W-1:0] inc,
        input logic signed [MOD_W-1:0] mod
    );
        longint             mod_val;
        longint             gain_val;
        longint             prev_val;
        longint             mod_term;
        longint             fb_term;
        logic [PHASE_W-1:0] addr;
        mod_val  = mod;
        gain_val = fb_gain;
        prev_val = prev_sample;
        mod_term = (mod_val * MOD_STEP) >>> (47 - PHASE_W);
        fb_term  = (gain_val * prev_val) <<< (PHASE_W - 27);
        tone_phase  = tone_phase + PHASE_W'(inc);
        addr        = tone_phase + mod_term[PHASE_W-1:0] + fb_term[PHASE_W-1:0];
        prev_sample = sine_lut[addr[PHASE_W-1 -: LUT_BITS]];
        return prev_sample;
    endfunction

    // receiver ready, with one long hold-off when requested
    always @(posedge aclk) begin
        if (hold_start && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("sample: unexpected beat, got %0d", $signed(m_tdata[SAMPLE_W-1:0]));
                fail_count++;
            end else begin
                want_sample = expected_samples.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== want_sample) begin
                    $error("sample mismatch: expected %0d, got %0d",
                           want_sample, $signed(m_tdata[SAMPLE_W-1:0]));
                    fail_count++;
                end
            end
        end
    end

    task automatic send_tick(input logic [INC_W-1:0] inc, input logic signed [MOD_W-1:0] mod);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, mod, inc};
        do @(posedge aclk); while (!s_tready);
        expected_samples.push_back(next_sample(inc, mod));
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == GAIN_ADDR) begin
            fb_gain = data[GAIN_W-1:0];
        end
        @(posedge aclk);
    endtask

    task automatic check_gain_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= GAIN_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[GAIN_W-1:0] !== fb_gain) begin
            $error("feedback_gain mismatch: expected %0d, got %0d",
                   fb_gain, prdata[GAIN_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_ticks(input int count);
        logic [INC_W-1:0]        inc;
        logic signed [MOD_W-1:0] mod;
        int                      pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                inc = INC_W'($urandom_range(0, 1 << 26));
            end else if (pick < 80) begin
                inc = INC_W'($urandom());
            end else if (pick < 90) begin
                inc = '0;
            end else begin
                inc = pick[0] ? INC_MAX : INC_QUARTER;
            end
            pick = $urandom_range(99);
            if (pick < 40) begin
                mod = MOD_W'($urandom());
            end else if (pick < 70) begin
                mod = MOD_W'($signed($urandom_range(0, 2000)) - 1000);
            end else if (pick < 85) begin
                mod = '0;
            end else begin
                mod = pick[0] ? MOD_MAX : MOD_MIN;
            end
            send_tick(inc, mod);
        end
    endtask

    task automatic test_reset_state();
        check_gain_readback();
        send_tick('0, '0);
        repeat (4) send_tick(INC_QUARTER, '0);
        drain();
    endtask

    task automatic test_field_extremes();
        send_tick(INC_MAX, '0);
        send_tick('0, MOD_MIN);
        send_tick('0, MOD_MAX);
        send_tick(INC_MAX, MOD_MIN);
        send_tick('0, -16'sd1);
        send_tick(INC_W'(1), 16'sd1);
        drain();
    endtask

    task automatic test_feedback_gain();
        apb_write(GAIN_ADDR, 32'habcd_ffff);
        apb_write(UNMAPPED_ADDR, 32'h0000_1234);
        check_gain_readback();
        send_tick(INC_QUARTER, '0);
        send_tick('0, '0);
        send_tick('0, MOD_MAX);
        send_tick(INC_MAX, MOD_MIN);
        drain();
        apb_write(GAIN_ADDR, 32'd4096);
        check_gain_readback();
        send_tick(INC_QUARTER, '0);
        send_tick('0, '0);
        send_tick('0, MOD_MIN);
        drain();
        apb_write(GAIN_ADDR, 32'd1);
        send_tick(INC_QUARTER, '0);
        send_tick(INC_QUARTER, MOD_MAX);
        drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall, input int gain,
                                       input int count);
        apb_write(GAIN_ADDR, PDATA_W'(gain));
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        send_random_ticks(count);
        drain();
    endtask

    task automatic test_output_hold_off();
        apb_write(GAIN_ADDR, PDATA_W'($urandom_range(0, 65535)));
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_start     <= 1'b1;
        send_random_ticks(40);
        drain();
    endtask

    initial begin
        tone_phase  = '0;
        prev_sample = '0;
        fb_gain     = '0;
        fill_sine_lut();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_field_extremes();
        test_feedback_gain();
        test_random_traffic(0, 0, $urandom_range(0, 65535), 200);
        test_random_traffic(75, 0, 65535, 200);
        test_random_traffic(0, 75, $urandom_range(0, 4096), 200);
        test_random_traffic(16, 16, 0, 200);
        test_output_hold_off();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/fmop_pkg.sv
src/fmop_sine_rom.sv
src/fm_operator_sine_feedback_core.sv
test/fm_operator_sine_feedback_core_test.sv
